### rtl/core/hc_pkg.sv
// Shared types, constants and arithmetic helpers of the 2x2 mod-26 Hill cipher.
package hc_pkg;

    localparam int unsigned ALPHA      = 26;
    localparam int unsigned NUM_STAGES = 7;
    localparam int unsigned LETTER_W   = 5;
    localparam int unsigned CHAR_W     = 8;
    localparam int unsigned OUT_W      = 7;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 5;

    // Bias that keeps the determinant difference non-negative (ALPHA squared).
    localparam logic [10:0] DET_BIAS   = 11'(ALPHA * ALPHA);
    // Reciprocal of ALPHA scaled by two to the sixteenth, rounded up.
    localparam logic [11:0] RECIP_26   = 12'd2521;
    localparam logic [OUT_W-1:0] ASCII_LOWER_A = 7'd97;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_TOP_LEFT     = 2'd0,
        CFG_KEY_TOP_RIGHT    = 2'd1,
        CFG_KEY_BOTTOM_LEFT  = 2'd2,
        CFG_KEY_BOTTOM_RIGHT = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        OP_ENCRYPT = 1'b0,
        OP_DECRYPT = 1'b1
    } t_op;

    // A 2x2 matrix of residues, used both for the key and the working matrix.
    typedef struct packed {
        logic [LETTER_W-1:0] tl;
        logic [LETTER_W-1:0] tr;
        logic [LETTER_W-1:0] bl;
        logic [LETTER_W-1:0] br;
    } t_mat;

    // Per-item fields that ride along the pipeline with the arithmetic.
    typedef struct packed {
        t_op                 op;
        logic [LETTER_W-1:0] p0;
        logic [LETTER_W-1:0] p1;
        logic                bad_char;
        logic                bad_key;
    } t_item;

    typedef logic [NUM_STAGES-1:0] t_stage_en;

    // Residue modulo 26 of an 11-bit value, by reciprocal multiply and one correction.
    function automatic logic [LETTER_W-1:0] mod26(input logic [10:0] x);
        logic [22:0] prod;
        logic [6:0]  q;
        logic [10:0] qm;
        logic [10:0] rem;
        prod = 23'(x) * 23'(RECIP_26);
        q    = prod[22:16];
        qm   = (11'(q) << 4) + (11'(q) << 3) + (11'(q) << 1);
        rem  = x - qm;
        if (rem >= 11'(ALPHA)) begin
            rem = rem - 11'(ALPHA);
        end
        return rem[LETTER_W-1:0];
    endfunction

    // Multiplicative inverse modulo 26; zero where the residue has none.
    function automatic logic [LETTER_W-1:0] inv26(input logic [LETTER_W-1:0] d);
        logic [LETTER_W-1:0] r;
        case (d)
            5'd1:    r = 5'd1;
            5'd3:    r = 5'd9;
            5'd5:    r = 5'd21;
            5'd7:    r = 5'd15;
            5'd9:    r = 5'd3;
            5'd11:   r = 5'd19;
            5'd15:   r = 5'd7;
            5'd17:   r = 5'd23;
            5'd19:   r = 5'd11;
            5'd21:   r = 5'd5;
            5'd23:   r = 5'd17;
            5'd25:   r = 5'd25;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

    // Letter index of an ASCII byte in either case; non-letters give zero.
    function automatic logic [LETTER_W-1:0] letter_value(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] v;
        v = '0;
        if (c inside {[8'd65:8'd90]}) begin
            v = c - 8'd65;
        end else if (c inside {[8'd97:8'd122]}) begin
            v = c - 8'd97;
        end
        return v[LETTER_W-1:0];
    endfunction

    function automatic logic is_letter(input logic [CHAR_W-1:0] c);
        return (c inside {[8'd65:8'd90], [8'd97:8'd122]});
    endfunction

    // Reduce a 5-bit register value into 0..25.
    function automatic logic [LETTER_W-1:0] reduce_key(input logic [LETTER_W-1:0] k);
        return (k >= 5'(ALPHA)) ? (k - 5'(ALPHA)) : k;
    endfunction

endpackage

### rtl/core/hc_in_if.sv
// Input channel of the Hill cipher: operation and a pair of ASCII characters.
interface hc_in_if;
    logic                          valid;
    logic                          ready;
    logic                          op;
    logic [hc_pkg::CHAR_W-1:0]     first_char;
    logic [hc_pkg::CHAR_W-1:0]     second_char;

    modport source (output valid, op, first_char, second_char, input ready);
    modport sink   (input valid, op, first_char, second_char, output ready);
endinterface

### rtl/core/hc_out_if.sv
// Output channel of the Hill cipher: two lowercase letters and two flags.
interface hc_out_if;
    logic                          valid;
    logic                          ready;
    logic [hc_pkg::OUT_W-1:0]      first_out;
    logic [hc_pkg::OUT_W-1:0]      second_out;
    logic                          bad_key;
    logic                          bad_char;

    modport source (output valid, first_out, second_out, bad_key, bad_char, input ready);
    modport sink   (input valid, first_out, second_out, bad_key, bad_char, output ready);
endinterface

### rtl/core/hc_pipe_ctrl.sv
// Valid bits and per-stage load enables of the Hill cipher pipeline.
module hc_pipe_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_ready,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output hc_pkg::t_stage_en o_en
);

    hc_pkg::t_stage_en r_valid;
    hc_pkg::t_stage_en n_valid;
    hc_pkg::t_stage_en en;

    // A stage loads when it is empty or its contents move on this cycle.
    always_comb begin
        en[hc_pkg::NUM_STAGES-1] = !r_valid[hc_pkg::NUM_STAGES-1] || i_out_ready;
        for (int k = hc_pkg::NUM_STAGES - 2; k >= 0; k--) begin
            en[k] = !r_valid[k] || en[k+1];
        end
    end

    always_comb begin
        n_valid = r_valid;
        if (en[0]) begin
            n_valid[0] = i_in_valid;
        end
        for (int k = 1; k < hc_pkg::NUM_STAGES; k++) begin
            if (en[k]) begin
                n_valid[k] = r_valid[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_en        = en;
    assign o_in_ready  = en[0];
    assign o_out_valid = r_valid[hc_pkg::NUM_STAGES-1];

endmodule

### rtl/core/hc_front.sv
// Entry stage: letter decoding of both characters and key reduction.
module hc_front (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic                      i_op,
    input  logic [hc_pkg::CHAR_W-1:0] i_first_char,
    input  logic [hc_pkg::CHAR_W-1:0] i_second_char,
    input  hc_pkg::t_mat              i_key,
    output hc_pkg::t_item             o_item,
    output hc_pkg::t_mat              o_key
);

    hc_pkg::t_item r_item;
    hc_pkg::t_mat  r_key;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item.op       <= hc_pkg::t_op'(i_op);
            r_item.p0       <= hc_pkg::letter_value(i_first_char);
            r_item.p1       <= hc_pkg::letter_value(i_second_char);
            r_item.bad_char <= !hc_pkg::is_letter(i_first_char) ||
                               !hc_pkg::is_letter(i_second_char);
            r_item.bad_key  <= 1'b0;
            r_key.tl        <= hc_pkg::reduce_key(i_key.tl);
            r_key.tr        <= hc_pkg::reduce_key(i_key.tr);
            r_key.bl        <= hc_pkg::reduce_key(i_key.bl);
            r_key.br        <= hc_pkg::reduce_key(i_key.br);
        end
    end

    assign o_item = r_item;
    assign o_key  = r_key;

endmodule

### rtl/core/hc_inverse.sv
// Four stages that build the working matrix: the key, or its inverse mod 26.
module hc_inverse (
    input  logic          i_clk,
    input  logic [3:0]    i_en,
    input  hc_pkg::t_item i_item,
    input  hc_pkg::t_mat  i_key,
    output hc_pkg::t_item o_item,
    output hc_pkg::t_mat  o_mat
);

    // Stage A: the two determinant products.
    hc_pkg::t_item r_item_a;
    hc_pkg::t_mat  r_key_a;
    logic [9:0]    r_prod_main;
    logic [9:0]    r_prod_anti;

    // Stage B: determinant inverse.
    hc_pkg::t_item              r_item_b;
    hc_pkg::t_mat               r_key_b;
    logic [hc_pkg::LETTER_W-1:0] r_dinv;

    // Stage C: scaled adjugate products.
    hc_pkg::t_item r_item_c;
    hc_pkg::t_mat  r_key_c;
    logic [9:0]    r_adj_tl;
    logic [9:0]    r_adj_tr;
    logic [9:0]    r_adj_bl;
    logic [9:0]    r_adj_br;

    // Stage D: working matrix.
    hc_pkg::t_item r_item_d;
    hc_pkg::t_mat  r_mat;

    logic [10:0]                 det_sum;
    logic [hc_pkg::LETTER_W-1:0] det;
    logic [hc_pkg::LETTER_W-1:0] dinv;
    logic [hc_pkg::LETTER_W-1:0] neg_tr;
    logic [hc_pkg::LETTER_W-1:0] neg_bl;
    hc_pkg::t_item               key_item;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_item_a    <= i_item;
            r_key_a     <= i_key;
            r_prod_main <= 10'(i_key.tl) * 10'(i_key.br);
            r_prod_anti <= 10'(i_key.tr) * 10'(i_key.bl);
        end
    end

    assign det_sum = 11'(r_prod_main) + hc_pkg::DET_BIAS - 11'(r_prod_anti);
    assign det     = hc_pkg::mod26(det_sum);
    assign dinv    = hc_pkg::inv26(det);

    // The item moves on with its bad-key flag filled in.
    always_comb begin
        key_item         = r_item_a;
        key_item.bad_key = (dinv == '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_item_b <= key_item;
            r_key_b  <= r_key_a;
            r_dinv   <= dinv;
        end
    end

    assign neg_tr = 5'(hc_pkg::ALPHA) - r_key_b.tr;
    assign neg_bl = 5'(hc_pkg::ALPHA) - r_key_b.bl;

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_item_c <= r_item_b;
            r_key_c  <= r_key_b;
            r_adj_tl <= 10'(r_dinv) * 10'(r_key_b.br);
            r_adj_tr <= 10'(r_dinv) * 10'(neg_tr);
            r_adj_bl <= 10'(r_dinv) * 10'(neg_bl);
            r_adj_br <= 10'(r_dinv) * 10'(r_key_b.tl);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_item_d <= r_item_c;
            if (r_item_c.op == hc_pkg::OP_DECRYPT) begin
                r_mat.tl <= hc_pkg::mod26(11'(r_adj_tl));
                r_mat.tr <= hc_pkg::mod26(11'(r_adj_tr));
                r_mat.bl <= hc_pkg::mod26(11'(r_adj_bl));
                r_mat.br <= hc_pkg::mod26(11'(r_adj_br));
            end else begin
                r_mat <= r_key_c;
            end
        end
    end

    assign o_item = r_item_d;
    assign o_mat  = r_mat;

endmodule

### rtl/core/hc_apply.sv
// Two stages that multiply the letter pair by the working matrix and format the result.
module hc_apply (
    input  logic                     i_clk,
    input  logic [1:0]               i_en,
    input  hc_pkg::t_item            i_item,
    input  hc_pkg::t_mat             i_mat,
    output logic [hc_pkg::OUT_W-1:0] o_first_out,
    output logic [hc_pkg::OUT_W-1:0] o_second_out,
    output logic                     o_bad_key,
    output logic                     o_bad_char
);

    hc_pkg::t_item              r_item;
    logic [10:0]                r_sum0;
    logic [10:0]                r_sum1;
    logic [hc_pkg::OUT_W-1:0]   r_first_out;
    logic [hc_pkg::OUT_W-1:0]   r_second_out;
    logic                       r_bad_key;
    logic                       r_bad_char;

    logic [hc_pkg::LETTER_W-1:0] c0;
    logic [hc_pkg::LETTER_W-1:0] c1;
    logic                        force_a;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_item <= i_item;
            r_sum0 <= 11'(i_mat.tl) * 11'(i_item.p0) + 11'(i_mat.tr) * 11'(i_item.p1);
            r_sum1 <= 11'(i_mat.bl) * 11'(i_item.p0) + 11'(i_mat.br) * 11'(i_item.p1);
        end
    end

    // Decryption under a key with no inverse yields the letter a for both outputs.
    assign force_a = (r_item.op == hc_pkg::OP_DECRYPT) && r_item.bad_key;
    assign c0      = force_a ? '0 : hc_pkg::mod26(r_sum0);
    assign c1      = force_a ? '0 : hc_pkg::mod26(r_sum1);

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_first_out  <= hc_pkg::ASCII_LOWER_A + 7'(c0);
            r_second_out <= hc_pkg::ASCII_LOWER_A + 7'(c1);
            r_bad_key    <= r_item.bad_key;
            r_bad_char   <= r_item.bad_char;
        end
    end

    assign o_first_out  = r_first_out;
    assign o_second_out = r_second_out;
    assign o_bad_key    = r_bad_key;
    assign o_bad_char   = r_bad_char;

endmodule

### rtl/core/hill_cipher_2x2_mod26.sv
// Top level of the two-letter Hill cipher over the 26-letter alphabet.
//
// This block enciphers or deciphers one pair of ASCII letters per beat with a
// 2x2 key matrix held in four 5-bit configuration registers (reset to the
// identity). Each input beat carries an operation bit and two characters of
// either case; each output beat carries two lowercase letters plus two flags:
// bad_key when the key determinant has no inverse modulo 26 (decryption then
// returns the letters a), and bad_char when either input byte was not a
// letter (that byte counts as a). Key values of 26 to 31 are used reduced
// modulo 26. The datapath is a seven-stage pipeline: it takes one beat every
// clock cycle as long as the output side keeps ready high, and the edge that
// accepts an input beat loads the first stage, from which the beat moves in
// order through the later stages to the output. When the output side stalls, the
// stages fill up behind the held result and input ready falls only once every
// stage is occupied, so no beat is lost or repeated. The register stages are
// letter decoding, the determinant products, the determinant inverse, the
// scaled adjugate, the working matrix, the matrix-vector product, and the
// final reduction that forms the letters.
//
// The key is sampled when a beat enters the pipeline, so a configuration
// write takes effect for the next beat accepted after it. Write the key only
// while no beat is in flight.

module hill_cipher_2x2_mod26 (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [hc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [hc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    hc_in_if.sink                         i_req,
    hc_out_if.source                      o_rsp
);

    // Key registers; the reset value is the identity matrix.
    hc_pkg::t_mat r_key;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key.tl <= 5'd1;
            r_key.tr <= 5'd0;
            r_key.bl <= 5'd0;
            r_key.br <= 5'd1;
        end else if (i_cfg_we) begin
            case (hc_pkg::t_cfg_idx'(i_cfg_idx))
                hc_pkg::CFG_KEY_TOP_LEFT:     r_key.tl <= i_cfg_data;
                hc_pkg::CFG_KEY_TOP_RIGHT:    r_key.tr <= i_cfg_data;
                hc_pkg::CFG_KEY_BOTTOM_LEFT:  r_key.bl <= i_cfg_data;
                hc_pkg::CFG_KEY_BOTTOM_RIGHT: r_key.br <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Stage enables come from a single valid chain; each stage loads when it
    // is empty or when the stage after it takes its contents.
    hc_pkg::t_stage_en en;

    hc_pipe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_out_ready (o_rsp.ready),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .o_en        (en)
    );

    hc_pkg::t_item front_item;
    hc_pkg::t_mat  front_key;
    hc_pkg::t_item inv_item;
    hc_pkg::t_mat  inv_mat;

    // Stage 1: decode letters, flag non-letters, reduce the key.
    hc_front u_front (
        .i_clk         (i_clk),
        .i_en          (en[0]),
        .i_op          (i_req.op),
        .i_first_char  (i_req.first_char),
        .i_second_char (i_req.second_char),
        .i_key         (r_key),
        .o_item        (front_item),
        .o_key         (front_key)
    );

    // Stages 2 to 5: determinant, its inverse, and the working matrix.
    hc_inverse u_inverse (
        .i_clk  (i_clk),
        .i_en   (en[4:1]),
        .i_item (front_item),
        .i_key  (front_key),
        .o_item (inv_item),
        .o_mat  (inv_mat)
    );

    // Stages 6 and 7: matrix-vector product and the output register.
    hc_apply u_apply (
        .i_clk        (i_clk),
        .i_en         (en[6:5]),
        .i_item       (inv_item),
        .i_mat        (inv_mat),
        .o_first_out  (o_rsp.first_out),
        .o_second_out (o_rsp.second_out),
        .o_bad_key    (o_rsp.bad_key),
        .o_bad_char   (o_rsp.bad_char)
    );

endmodule
